// ===== rtl/stsde_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stsde_pkg
// shared types, widths and codes for the sorted table block
// ----------------------------------------------------------------------------
package stsde_pkg;

  localparam int CAPACITY    = 16;  // table cells, 2 to 16
  localparam int MAX_RESULTS = 16;  // entries emitted by one dump at most
  localparam int VAL_W       = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int MIDX_W      = 4;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_EDIT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cmd_t                    command;
    logic signed [VAL_W-1:0] key_value;
    logic signed [VAL_W-1:0] replacement_value;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [MIDX_W-1:0]       match_index;
    logic signed [VAL_W-1:0] entry_value;
    logic                    entry_valid;
    logic [COUNT_OUT_W-1:0]  entry_count;
    logic                    last;
  } out_item_t;

  // per-cell compare flags against the broadcast operand
  typedef struct packed {
    logic gt;
    logic ge;
    logic eq;
  } cell_stat_t;

  // per-cell placement info derived from the entry count
  typedef struct packed {
    logic occupied;
    logic at_tail;
  } cell_pos_t;

endpackage

`default_nettype wire

// ===== rtl/stsde_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stsde_cell
// one slot of the sorted table: holds a value, compares, shifts to neighbors
// ----------------------------------------------------------------------------
module stsde_cell (
  input  wire logic                             clk,
  input  wire stsde_pkg::cell_op_t              op,
  input  wire logic signed [stsde_pkg::VAL_W-1:0] operand,
  input  wire stsde_pkg::cell_pos_t             pos,
  input  wire logic signed [stsde_pkg::VAL_W-1:0] prv_val,
  input  wire logic                             prv_gt,
  input  wire logic signed [stsde_pkg::VAL_W-1:0] nxt_val,
  output logic signed [stsde_pkg::VAL_W-1:0]    val,
  output stsde_pkg::cell_stat_t                 stat
);

  logic signed [stsde_pkg::VAL_W-1:0] val_r;
  logic signed [stsde_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    stat.gt = pos.occupied && ($signed(val_r) >  $signed(operand));
    stat.ge = pos.occupied && ($signed(val_r) >= $signed(operand));
    stat.eq = pos.occupied && (val_r == operand);
  end

  always_comb begin
    val_nxt = val_r;
    case (op)
      stsde_pkg::OP_INSERT: begin
        // left neighbor moved right, or the new value lands here
        if (prv_gt) begin
          val_nxt = prv_val;
        end else if (stat.gt || pos.at_tail) begin
          val_nxt = operand;
        end
      end
      stsde_pkg::OP_REMOVE: begin
        // close the gap left by the first match
        if (stat.ge) begin
          val_nxt = nxt_val;
        end
      end
      stsde_pkg::OP_ROTATE: begin
        val_nxt = nxt_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

// ===== rtl/sorted_table_search_delete_edit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_search_delete_edit
// sorted table of signed values with insert, search, delete-all and edit
// ----------------------------------------------------------------------------
// The table lives in a ring of CAPACITY cells kept in ascending order, cell 0
// holding the smallest entry. One command is worked on at a time; in_stall is
// high from the transfer until the command is finished. Insert and search are
// a capture, then one insert/compare step in every cell at once, and give one
// result. Delete removes one matching entry per cycle: capture, decode, one
// removal per match, then one final compare that finds no match, before the
// dump; edit then reinserts the new value once per removed entry. The dump
// rotates the ring one cell per cycle, unless an emitting step waits on the
// output, through all CAPACITY steps, emitting cell 0 on each of the first
// min(count, MAX_RESULTS) steps, which leaves the table in its original
// order; an empty table gives one result with entry_valid low instead. The
// output register lets a result wait for out_stall without losing the step;
// rotation pauses on an emitting step while a result is held back.
// ----------------------------------------------------------------------------
module sorted_table_search_delete_edit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire stsde_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output stsde_pkg::out_item_t      out_data
);

  localparam int CAP   = stsde_pkg::CAPACITY;
  localparam int IDX_W = stsde_pkg::IDX_W;
  localparam int CNT_W = stsde_pkg::CNT_W;
  localparam int VAL_W = stsde_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_REINS,
    S_DUMP
  } state_t;

  state_t                  state_r;
  stsde_pkg::cmd_t         cmd_r;
  logic signed [VAL_W-1:0] key_r;
  logic signed [VAL_W-1:0] repl_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        removed_r;
  logic                    found_r;
  logic [IDX_W-1:0]        step_r;
  logic                    out_valid_r;
  stsde_pkg::out_item_t    out_data_r;

  // ring of cells
  stsde_pkg::cell_op_t     cell_op;
  logic signed [VAL_W-1:0] operand;
  logic signed [VAL_W-1:0] cell_val [CAP];
  stsde_pkg::cell_stat_t   cell_stat [CAP];
  stsde_pkg::cell_pos_t    cell_pos [CAP];
  logic [CAP-1:0]          eq_vec;

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      localparam int NXT = (gi + 1) % CAP;
      localparam int PRV = (gi + CAP - 1) % CAP;

      assign cell_pos[gi].occupied = count_r > CNT_W'(gi);
      assign cell_pos[gi].at_tail  = count_r == CNT_W'(gi);
      assign eq_vec[gi]            = cell_stat[gi].eq;

      stsde_cell u_cell (
        .clk     (clk),
        .op      (cell_op),
        .operand (operand),
        .pos     (cell_pos[gi]),
        .prv_val (cell_val[PRV]),
        .prv_gt  ((gi == 0) ? 1'b0 : cell_stat[PRV].gt),
        .nxt_val (cell_val[NXT]),
        .val     (cell_val[gi]),
        .stat    (cell_stat[gi])
      );
    end
  endgenerate

  // derived control
  logic             any_eq;
  logic [IDX_W-1:0] first_idx;
  logic             ofree;
  logic             full;
  logic [CNT_W-1:0] emit_n;
  logic             dump_emit;
  logic             dump_last;
  logic             rotate_en;
  logic             out_load;
  stsde_pkg::status_t dump_status;

  assign any_eq   = |eq_vec;
  assign ofree    = !out_valid_r || !out_stall;
  assign full     = count_r == CNT_W'(CAP);
  assign operand  = (state_r == S_REINS) ? repl_r : key_r;
  assign emit_n   = (int'(count_r) > stsde_pkg::MAX_RESULTS) ?
                    CNT_W'(stsde_pkg::MAX_RESULTS) : count_r;
  assign dump_emit = CNT_W'(step_r) < emit_n;
  assign dump_last = (CNT_W'(step_r) + CNT_W'(1)) == emit_n;
  // rotation waits only on steps that emit a result
  assign rotate_en = (count_r != '0) && (!dump_emit || ofree);
  assign dump_status = found_r ? stsde_pkg::ST_OK : stsde_pkg::ST_NOT_FOUND;
  // a new result enters the output register this cycle
  assign out_load = ofree &&
                    (((state_r == S_EXEC) &&
                      (cmd_r inside {stsde_pkg::CMD_INSERT, stsde_pkg::CMD_SEARCH})) ||
                     ((state_r == S_DUMP) && ((count_r == '0) || dump_emit)));

  // first match, scanning from the top so the lowest index wins
  always_comb begin
    first_idx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (eq_vec[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  // what the ring does this cycle
  always_comb begin
    cell_op = stsde_pkg::OP_HOLD;
    case (state_r)
      S_EXEC: begin
        if (cmd_r == stsde_pkg::CMD_INSERT && ofree && !full) begin
          cell_op = stsde_pkg::OP_INSERT;
        end
      end
      S_REMOVE: begin
        if (any_eq) begin
          cell_op = stsde_pkg::OP_REMOVE;
        end
      end
      S_REINS: begin
        cell_op = stsde_pkg::OP_INSERT;
      end
      S_DUMP: begin
        if (rotate_en) begin
          cell_op = stsde_pkg::OP_ROTATE;
        end
      end
      default: begin
        cell_op = stsde_pkg::OP_HOLD;
      end
    endcase
  end

  function automatic stsde_pkg::out_item_t make_out(
    input stsde_pkg::status_t      st,
    input logic [IDX_W-1:0]        midx,
    input logic signed [VAL_W-1:0] value,
    input logic                    valid,
    input logic [CNT_W-1:0]        cnt,
    input logic                    last
  );
    stsde_pkg::out_item_t o;
    o.status      = st;
    o.match_index = stsde_pkg::MIDX_W'(midx);
    o.entry_value = value;
    o.entry_valid = valid;
    o.entry_count = stsde_pkg::COUNT_OUT_W'(cnt);
    o.last        = last;
    return o;
  endfunction

  // sequencer, entry count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      removed_r   <= '0;
      found_r     <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a held result stays until taken, a new one replaces a taken one
      out_valid_r <= out_load || (out_valid_r && out_stall);
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= in_data.command;
            key_r     <= in_data.key_value;
            repl_r    <= in_data.replacement_value;
            removed_r <= '0;
            found_r   <= 1'b0;
            step_r    <= '0;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_r)
            stsde_pkg::CMD_INSERT: begin
              if (ofree) begin
                if (full) begin
                  out_data_r <= make_out(stsde_pkg::ST_FULL, '0, '0, 1'b0, count_r, 1'b1);
                end else begin
                  out_data_r <= make_out(stsde_pkg::ST_OK, '0, '0, 1'b0,
                                         count_r + CNT_W'(1), 1'b1);
                  count_r    <= count_r + CNT_W'(1);
                end
                state_r <= S_IDLE;
              end
            end
            stsde_pkg::CMD_SEARCH: begin
              if (ofree) begin
                if (any_eq) begin
                  out_data_r <= make_out(stsde_pkg::ST_OK, first_idx, '0, 1'b0,
                                         count_r, 1'b1);
                end else begin
                  out_data_r <= make_out(stsde_pkg::ST_NOT_FOUND, '0, '0, 1'b0,
                                         count_r, 1'b1);
                end
                state_r <= S_IDLE;
              end
            end
            default: begin
              state_r <= S_REMOVE;
            end
          endcase
        end
        S_REMOVE: begin
          if (any_eq) begin
            count_r   <= count_r - CNT_W'(1);
            removed_r <= removed_r + CNT_W'(1);
            found_r   <= 1'b1;
          end else if (removed_r != '0 && cmd_r == stsde_pkg::CMD_EDIT) begin
            state_r <= S_REINS;
          end else begin
            state_r <= S_DUMP;
          end
        end
        S_REINS: begin
          // every removed slot is free again, so the table cannot be full
          count_r   <= count_r + CNT_W'(1);
          removed_r <= removed_r - CNT_W'(1);
          if (removed_r == CNT_W'(1)) begin
            state_r <= S_DUMP;
          end
        end
        S_DUMP: begin
          if (count_r == '0) begin
            if (ofree) begin
              out_data_r  <= make_out(dump_status, '0, '0, 1'b0, count_r, 1'b1);
              state_r     <= S_IDLE;
            end
          end else if (rotate_en) begin
            if (dump_emit) begin
              out_data_r  <= make_out(dump_status, '0, cell_val[0], 1'b1,
                                      count_r, dump_last);
            end
            step_r <= step_r + IDX_W'(1);
            if (step_r == IDX_W'(CAP - 1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupied cells ascend
  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < CAP - 1; i++) begin
      if (cell_pos[i + 1].occupied && ($signed(cell_val[i]) > $signed(cell_val[i + 1]))) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAP))
    else $error("entry count above capacity");

  a_sorted_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> sorted_ok)
    else $error("table out of order between commands");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REMOVE && any_eq) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("match removal did not drop one entry");

  a_reinsert_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REINS |-> removed_r != '0)
    else $error("reinsert with nothing removed");

endmodule

`default_nettype wire
